// File: rtl/dtbc_pkg.sv
// shared constants, types and the stream signature table for the delimited
// text to binary copy unit; used by every module in rtl
package dtbc_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int MAX_FIELD   = 128;
  localparam int FIELD_AW    = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;
  localparam int LEN_W       = $clog2(MAX_FIELD + 1);
  localparam int POS_W       = (MAX_FIELD + 7 > 19) ? $clog2(MAX_FIELD + 7) : 5;

  localparam logic [1:0] MODE_DATA   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MISSING   = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED = 3'd2;
  localparam logic [2:0] ERR_ESCAPE    = 3'd3;
  localparam logic [2:0] ERR_SATURATED = 3'd4;

  localparam logic [2:0] TYPE_CHAR   = 3'd0;
  localparam logic [2:0] TYPE_SHORT  = 3'd1;
  localparam logic [2:0] TYPE_INT    = 3'd2;
  localparam logic [2:0] TYPE_LONG   = 3'd3;
  localparam logic [2:0] TYPE_BINARY = 3'd4;

  localparam logic CFG_COLUMN_COUNT = 1'b0;
  localparam logic CFG_COLUMN_TYPES = 1'b1;

  localparam logic [7:0] BYTE_PIPE   = 8'h7C;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_NL     = 8'h0A;

  localparam int SIG_LEN = 19;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GEN,
    S_MISS
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic run;
    logic miss_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic gen_done;
    logic miss;
    logic out_free;
  } dp_stat_t;

  // file signature followed by flags and extension length (all zero)
  function automatic logic [7:0] sig_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h50;
      5'd1:    b = 8'h47;
      5'd2:    b = 8'h43;
      5'd3:    b = 8'h4F;
      5'd4:    b = 8'h50;
      5'd5:    b = 8'h59;
      5'd6:    b = 8'h0A;
      5'd7:    b = 8'hFF;
      5'd8:    b = 8'h0D;
      5'd9:    b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/dtbc_ctrl.sv
// controller for the copy unit: sequences item accept, byte generation and
// the missing-field result; depends on dtbc_pkg
module dtbc_ctrl import dtbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_GEN;
      end
      S_GEN: begin
        if (stat.gen_done) state_nxt = stat.miss ? S_MISS : S_IDLE;
      end
      S_MISS: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.run     = 1'b0;
    cmd.miss_ld = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_GEN:   cmd.run = 1'b1;
      S_MISS:  cmd.miss_ld = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/dtbc_dp.sv
// datapath for the copy unit: config registers, text parser, field buffer,
// byte generator, word packer and output register; depends on dtbc_pkg
module dtbc_dp import dtbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [63:0] out_data,
  output logic [3:0]  out_count,
  output logic        out_last,
  output logic [2:0]  out_error
);

  // configuration
  logic [4:0]  col_cnt_r;
  logic [47:0] col_types_r;

  // parse state
  logic             esc_r, esc_nxt;
  logic [4:0]       col_idx_r, col_idx_nxt;
  logic             hdr_sent_r, hdr_sent_nxt;
  logic [63:0]      num_r, num_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             sat_r, sat_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;

  // job description
  logic             sig_r, sig_nxt;
  logic             bin_r, bin_nxt;
  logic             miss_r, miss_nxt;
  logic [2:0]       err_r, err_nxt;
  logic [47:0]      pre_r, pre_nxt;
  logic [2:0]       pre_len_r, pre_len_nxt;
  logic [63:0]      val_r, val_nxt;
  logic [POS_W-1:0] n_r, n_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  // packer and output
  logic [63:0] acc_r, acc_nxt, acc_base;
  logic [3:0]  acc_n_r, acc_n_nxt, cnt_base;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_count_r;
  logic        out_last_r;
  logic [2:0]  out_err_r;

  // field buffer
  logic [7:0]          store [MAX_FIELD];
  logic [7:0]          rdata_r;
  logic                mem_we;
  logic [FIELD_AW-1:0] rd_addr;

  logic [4:0]       eff_cnt;
  logic             col_live;
  logic [2:0]       cur_type;
  logic             is_ws, is_digit, do_feed;
  logic [63:0]      num_mx;
  logic [67:0]      prod;
  logic             num_over;
  logic [LEN_W-1:0] vlen;
  logic [31:0]      len_word;
  logic [POS_W-1:0] off;
  logic [7:0]       gbyte;
  logic             app, flush, out_free;

  always_comb begin
    if (col_cnt_r == 5'd0) eff_cnt = 5'd1;
    else if (col_cnt_r > 5'(MAX_COLUMNS)) eff_cnt = 5'(MAX_COLUMNS);
    else eff_cnt = col_cnt_r;
  end

  assign col_live = col_idx_r < eff_cnt;
  assign cur_type = col_types_r[3 * col_idx_r[3:0] +: 3];
  assign is_ws    = in_byte inside {8'h20, [8'h09:8'h0D]};
  assign is_digit = in_byte inside {[8'h30:8'h39]};
  assign do_feed  = cmd.load && in_mode == MODE_DATA &&
                    (esc_r || (in_byte != BYTE_BSLASH && in_byte != BYTE_PIPE &&
                               in_byte != BYTE_NL));

  always_comb begin
    case (cur_type)
      TYPE_SHORT: num_mx = 64'h0000_0000_0000_FFFF;
      TYPE_INT:   num_mx = 64'h0000_0000_FFFF_FFFF;
      default:    num_mx = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  end

  // value * 10 + digit, checked against the type maximum
  assign prod = ({4'b0, num_r} << 3) + ({4'b0, num_r} << 1) + {64'b0, in_byte[3:0]};
  assign num_over = prod > {4'b0, num_mx};

  always_comb begin
    case (cur_type)
      TYPE_CHAR:  vlen = LEN_W'(1);
      TYPE_SHORT: vlen = LEN_W'(2);
      TYPE_INT:   vlen = LEN_W'(4);
      TYPE_LONG:  vlen = LEN_W'(8);
      default:    vlen = flen_r;
    endcase
  end
  assign len_word = 32'(vlen);

  always_comb begin
    esc_nxt      = esc_r;
    col_idx_nxt  = col_idx_r;
    hdr_sent_nxt = hdr_sent_r;
    num_nxt      = num_r;
    phase_nxt    = phase_r;
    sat_nxt      = sat_r;
    char_nxt     = char_r;
    flen_nxt     = flen_r;
    sig_nxt      = sig_r;
    bin_nxt      = bin_r;
    miss_nxt     = miss_r;
    err_nxt      = err_r;
    pre_nxt      = pre_r;
    pre_len_nxt  = pre_len_r;
    val_nxt      = val_r;
    n_nxt        = n_r;
    mem_we       = 1'b0;
    if (cmd.load) begin
      sig_nxt  = 1'b0;
      bin_nxt  = 1'b0;
      miss_nxt = 1'b0;
      err_nxt  = ERR_NONE;
      n_nxt    = '0;
      case (in_mode)
        MODE_START: begin
          esc_nxt = 1'b0; col_idx_nxt = '0; hdr_sent_nxt = 1'b0;
          num_nxt = '0; phase_nxt = '0; sat_nxt = 1'b0; char_nxt = '0; flen_nxt = '0;
          sig_nxt = 1'b1;
          n_nxt   = POS_W'(SIG_LEN);
        end
        MODE_END: begin
          if (esc_r) err_nxt = ERR_ESCAPE;
          else if (hdr_sent_r && col_live) err_nxt = ERR_MISSING;
          pre_nxt     = {16'hFFFF, 32'h0};
          pre_len_nxt = 3'd2;
          n_nxt       = POS_W'(2);
          esc_nxt = 1'b0; col_idx_nxt = '0; hdr_sent_nxt = 1'b0;
          num_nxt = '0; phase_nxt = '0; sat_nxt = 1'b0; char_nxt = '0; flen_nxt = '0;
        end
        MODE_DATA: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (in_byte == BYTE_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (in_byte == BYTE_PIPE || in_byte == BYTE_NL) begin
            if (col_live) begin
              bin_nxt = cur_type[2];
              if (!hdr_sent_r) begin
                pre_nxt     = {11'b0, eff_cnt, len_word};
                pre_len_nxt = 3'd6;
              end else begin
                pre_nxt     = {len_word, 16'h0};
                pre_len_nxt = 3'd4;
              end
              n_nxt = POS_W'(hdr_sent_r ? 3'd4 : 3'd6) + POS_W'(vlen);
              case (cur_type)
                TYPE_CHAR:  val_nxt = {char_r, 56'b0};
                TYPE_SHORT: val_nxt = {num_r[15:0], 48'b0};
                TYPE_INT:   val_nxt = {num_r[31:0], 32'b0};
                default:    val_nxt = num_r;
              endcase
              if (sat_r && cur_type != TYPE_CHAR)
                err_nxt = cur_type[2] ? ERR_TRUNCATED : ERR_SATURATED;
              num_nxt = '0; phase_nxt = '0; sat_nxt = 1'b0; char_nxt = '0; flen_nxt = '0;
              col_idx_nxt  = col_idx_r + 5'd1;
              hdr_sent_nxt = 1'b1;
            end
            if (in_byte == BYTE_NL) begin
              miss_nxt     = col_live && (col_idx_r + 5'd1 < eff_cnt);
              col_idx_nxt  = '0;
              hdr_sent_nxt = 1'b0;
              num_nxt = '0; phase_nxt = '0; sat_nxt = 1'b0; char_nxt = '0; flen_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (do_feed && col_live) begin
      if (cur_type == TYPE_CHAR) begin
        if (phase_r == 2'd0 && !is_ws) begin
          char_nxt  = in_byte;
          phase_nxt = 2'd1;
        end
      end else if (cur_type[2]) begin
        if (flen_r < LEN_W'(MAX_FIELD)) begin
          mem_we   = 1'b1;
          flen_nxt = flen_r + LEN_W'(1);
        end else begin
          sat_nxt = 1'b1;
        end
      end else if (!(phase_r == 2'd0 && is_ws)) begin
        if (phase_r <= 2'd1 && is_digit) begin
          phase_nxt = 2'd1;
          if (num_over) begin
            num_nxt = num_mx;
            sat_nxt = 1'b1;
          end else begin
            num_nxt = prod[63:0];
          end
        end else begin
          phase_nxt = 2'd2;
        end
      end
    end
  end

  // byte generator
  assign off = pos_r - POS_W'(pre_len_r);
  always_comb begin
    if (sig_r) gbyte = sig_byte(pos_r[4:0]);
    else if (pos_r < POS_W'(pre_len_r)) gbyte = pre_r[47 - 8 * pos_r[2:0] -: 8];
    else if (bin_r) gbyte = rdata_r;
    else gbyte = val_r[63 - 8 * off[2:0] -: 8];
  end

  assign out_free = !out_valid_r || out_ready;
  assign app      = cmd.run && acc_n_r < 4'd8 && pos_r < n_r;
  assign flush    = cmd.run && acc_n_r != 4'd0 && (acc_n_r == 4'd8 || pos_r == n_r) &&
                    out_free;
  assign acc_base = flush ? 64'b0 : acc_r;
  assign cnt_base = flush ? 4'd0 : acc_n_r;
  assign acc_nxt  = app ? (acc_base | ({gbyte, 56'b0} >> {cnt_base[2:0], 3'b000})) : acc_base;
  assign acc_n_nxt = cnt_base + {3'b0, app};

  always_comb begin
    if (cmd.load) pos_nxt = '0;
    else if (app) pos_nxt = pos_r + POS_W'(1);
    else pos_nxt = pos_r;
  end

  // prefetch the buffer byte for the next position
  assign rd_addr = FIELD_AW'(pos_nxt - POS_W'(pre_len_r));

  always_ff @(posedge clk) begin
    if (mem_we) store[flen_r[FIELD_AW-1:0]] <= in_byte;
    rdata_r <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= 5'd1;
      col_types_r <= '0;
      esc_r       <= 1'b0;
      col_idx_r   <= '0;
      hdr_sent_r  <= 1'b0;
      num_r       <= '0;
      phase_r     <= '0;
      sat_r       <= 1'b0;
      char_r      <= '0;
      flen_r      <= '0;
      sig_r       <= 1'b0;
      bin_r       <= 1'b0;
      miss_r      <= 1'b0;
      err_r       <= ERR_NONE;
      n_r         <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      acc_n_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_COLUMN_COUNT) col_cnt_r <= cfg_data[4:0];
      if (cfg_we && cfg_index == CFG_COLUMN_TYPES) col_types_r <= cfg_data;
      esc_r      <= esc_nxt;
      col_idx_r  <= col_idx_nxt;
      hdr_sent_r <= hdr_sent_nxt;
      num_r      <= num_nxt;
      phase_r    <= phase_nxt;
      sat_r      <= sat_nxt;
      char_r     <= char_nxt;
      flen_r     <= flen_nxt;
      sig_r      <= sig_nxt;
      bin_r      <= bin_nxt;
      miss_r     <= miss_nxt;
      err_r      <= err_nxt;
      n_r        <= n_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      acc_n_r    <= acc_n_nxt;
      if (flush || cmd.miss_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pre_r     <= pre_nxt;
    pre_len_r <= pre_len_nxt;
    val_r     <= val_nxt;
    if (flush) begin
      out_data_r  <= acc_r;
      out_count_r <= acc_n_r;
      out_last_r  <= pos_r == n_r && !miss_r;
      out_err_r   <= err_r;
    end else if (cmd.miss_ld) begin
      out_data_r  <= '0;
      out_count_r <= 4'd0;
      out_last_r  <= 1'b1;
      out_err_r   <= ERR_MISSING;
    end
  end

  assign stat.gen_done = pos_r == n_r && acc_n_r == 4'd0;
  assign stat.miss     = miss_r;
  assign stat.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;
  assign out_error = out_err_r;

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_n_r <= 4'd8)
    else $error("packer count above eight");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= n_r)
    else $error("byte position past job length");

  a_flen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flen_r <= LEN_W'(MAX_FIELD))
    else $error("field length past buffer size");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_count_r == 4'd0 |-> out_err_r == ERR_MISSING && out_last_r)
    else $error("empty result that is not a missing-field marker");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> stat.gen_done && acc_n_r == 4'd0)
    else $error("item loaded while a job is still in progress");

endmodule

// File: rtl/delimited_text_to_binary_copy_unit.sv
// Delimited text to binary copy unit.
// Input channel (in_valid/in_ready): one item per text byte with in_mode 0,
// a start item (mode 1) that emits the 19-byte stream header, and an end
// item (mode 2) that emits the 0xFFFF trailer. Mode 3 is ignored.
// Output channel (out_valid/out_ready): big-endian words of up to eight
// bytes, first byte in bits 63:56, out_last on the final word of an item.
// Config port: cfg_we writes cfg_data into register cfg_index (0 column
// count, 1 column types); the user must write only while the block is
// idle, a rule that the block itself leaves unchecked.
// Flow: an item is taken, then its bytes are generated one per cycle while
// the packer word is not full and are packed; each full or final word then
// moves into the output register, and once the job is done the controller
// returns to idle, after first loading a missing-field marker if a row
// ended early; a closed binary field of L bytes gives L + 4 output bytes,
// or L + 6 with the row header. The next item is taken only after the last
// word has entered the output register and the controller is idle again.
// A stalled receiver holds the output register, and byte generation stops
// once the packer word is full.
// Reset (rst_n low, synchronous) clears the parse state and sets the column
// count to 1 and all column types to char. Depends on dtbc_pkg.
module delimited_text_to_binary_copy_unit import dtbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic [3:0]  out_count,
  output logic        out_last,
  output logic [2:0]  out_error
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dtbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (in_mode),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_count (out_count),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

// File: test/dtbc_checker.sv
`timescale 1ns / 1ps
// checker for the delimited text to binary copy unit: follows config writes
// and accepted items, predicts the output words and compares them in order
// depends on dtbc_pkg
module dtbc_checker import dtbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_data,
  input  logic [3:0]  out_count,
  input  logic        out_last,
  input  logic [2:0]  out_error,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [2:0]  err;
  } copy_word_t;

  copy_word_t  word_q[$];
  logic [7:0]  byte_q[$];

  logic [4:0]  col_count;
  logic [47:0] col_types;
  logic        esc_pend;
  logic [4:0]  col_idx;
  logic        hdr_sent;
  logic [63:0] num_val;
  logic [1:0]  num_phase;
  logic        sat;
  logic [7:0]  chr_val;
  logic [7:0]  field_buf [MAX_FIELD];
  logic [8:0]  field_len;

  logic [7:0] signature [11] = '{8'h50, 8'h47, 8'h43, 8'h4F, 8'h50, 8'h59,
                                 8'h0A, 8'hFF, 8'h0D, 8'h0A, 8'h00};

  function automatic int eff_cols();
    int c;
    c = col_count;
    if (c == 0) c = 1;
    if (c > MAX_COLUMNS) c = MAX_COLUMNS;
    return c;
  endfunction

  function automatic logic [2:0] col_type(int i);
    if (i >= 16) return TYPE_BINARY;
    return col_types[3*i +: 3];
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic add_byte(logic [7:0] b);
    byte_q.insert(byte_q.size(), b);
  endtask

  task automatic add_word(copy_word_t w);
    word_q.insert(word_q.size(), w);
  endtask

  task automatic clear_field();
    num_val   = '0;
    num_phase = '0;
    sat       = 1'b0;
    chr_val   = '0;
    field_len = '0;
  endtask

  task automatic clear_parse();
    esc_pend = 1'b0;
    col_idx  = '0;
    hdr_sent = 1'b0;
    clear_field();
  endtask

  task automatic put_be(logic [63:0] v, int nb);
    for (int i = nb - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endtask

  // pack the pending bytes into words of up to eight
  task automatic flush_words(logic [2:0] err);
    copy_word_t w;
    while (byte_q.size() > 0) begin
      w = '0;
      w.err = err;
      while (w.count < 8 && byte_q.size() > 0) begin
        w.data[56 - 8*w.count +: 8] = byte_q.pop_front();
        w.count++;
      end
      add_word(w);
    end
  endtask

  task automatic feed(logic [7:0] b);
    logic [2:0]  t;
    logic [63:0] mx, d;
    if (col_idx >= eff_cols()) return;
    t = col_type(col_idx);
    if (t == TYPE_CHAR) begin
      if (num_phase == 0 && !is_space(b)) begin
        chr_val   = b;
        num_phase = 1;
      end
    end else if (t > TYPE_LONG) begin
      if (field_len < MAX_FIELD) begin
        field_buf[field_len[6:0]] = b;
        field_len++;
      end else begin
        sat = 1'b1;
      end
    end else begin
      mx = (t == TYPE_SHORT) ? 64'hFFFF : (t == TYPE_INT) ? 64'hFFFF_FFFF : '1;
      if (num_phase == 0 && is_space(b)) return;
      if (num_phase <= 1 && b >= "0" && b <= "9") begin
        d = 64'(b - 8'h30);
        num_phase = 1;
        if (num_val > (mx - d) / 10) begin
          num_val = mx;
          sat     = 1'b1;
        end else begin
          num_val = num_val * 10 + d;
        end
      end else begin
        num_phase = 2;
      end
    end
  endtask

  task automatic close_field();
    logic [2:0] t, err;
    int sz;
    if (col_idx >= eff_cols()) return;
    err = ERR_NONE;
    if (!hdr_sent) begin
      put_be(64'(eff_cols()), 2);
      hdr_sent = 1'b1;
    end
    t = col_type(col_idx);
    if (t == TYPE_CHAR) begin
      put_be(64'd1, 4);
      add_byte(chr_val);
    end else if (t > TYPE_LONG) begin
      put_be(64'(field_len), 4);
      for (int i = 0; i < field_len; i++) add_byte(field_buf[i]);
      if (sat) err = ERR_TRUNCATED;
    end else begin
      sz = (t == TYPE_SHORT) ? 2 : (t == TYPE_INT) ? 4 : 8;
      put_be(64'(sz), 4);
      put_be(num_val, sz);
      if (sat) err = ERR_SATURATED;
    end
    flush_words(err);
    clear_field();
    col_idx++;
  endtask

  task automatic predict_item(logic [1:0] mode, logic [7:0] b);
    int         n0;
    logic [2:0] err;
    copy_word_t w;
    n0 = word_q.size();
    if (mode == MODE_START) begin
      clear_parse();
      for (int i = 0; i < 11; i++) add_byte(signature[i]);
      put_be(64'd0, 8);
      flush_words(ERR_NONE);
    end else if (mode == MODE_END) begin
      err = ERR_NONE;
      if (esc_pend) err = ERR_ESCAPE;
      else if (hdr_sent && col_idx < eff_cols()) err = ERR_MISSING;
      put_be(64'hFFFF, 2);
      flush_words(err);
      clear_parse();
    end else if (mode == MODE_DATA) begin
      if (esc_pend) begin
        feed(b);
        esc_pend = 1'b0;
      end else if (b == BYTE_BSLASH) begin
        esc_pend = 1'b1;
      end else if (b == BYTE_PIPE) begin
        close_field();
      end else if (b == BYTE_NL) begin
        close_field();
        if (col_idx < eff_cols()) begin
          w = '0;
          w.err = ERR_MISSING;
          add_word(w);
        end
        col_idx  = '0;
        hdr_sent = 1'b0;
        clear_field();
      end else begin
        feed(b);
      end
    end
    if (word_q.size() > n0) begin
      w = word_q.pop_back();
      w.last = 1'b1;
      add_word(w);
    end
  endtask

  always @(posedge clk) begin
    copy_word_t exp_w;
    if (!rst_n) begin
      col_count  = 5'd1;
      col_types  = '0;
      fail_count = 0;
      clear_parse();
      word_q.delete();
      byte_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (word_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: data %h count %0d last %0d error %0d",
                     out_data, out_count, out_last, out_error);
        end else begin
          exp_w = word_q.pop_front();
          if (out_data !== exp_w.data || out_count !== exp_w.count ||
              out_last !== exp_w.last || out_error !== exp_w.err) begin
            fail_count++;
            if (fail_count <= 10)
              $display("word mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                       exp_w.data, exp_w.count, exp_w.last, exp_w.err,
                       out_data, out_count, out_last, out_error);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_COLUMN_COUNT) col_count = cfg_data[4:0];
        else col_types = cfg_data;
      end
      if (in_valid && in_ready) predict_item(in_mode, in_byte);
    end
    outstanding = word_q.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// top of the testbench for the delimited text to binary copy unit: clock,
// reset, text row stimulus, config and receiver stalls; uses dtbc_checker
module tb;
  import dtbc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        out_last;
  logic [2:0]  out_error;
  int          fail_count, outstanding;

  int          send_idle = 0, recv_stall = 0, hold_off = 0;
  int          items_sent = 0, cycles = 0;
  logic [4:0]  cur_count = 5'd1;
  logic [47:0] cur_types = '0;

  delimited_text_to_binary_copy_unit DUT (.*);

  dtbc_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_item(logic [1:0] mode, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_item(MODE_DATA, s[i]);
  endtask

  // text byte inside a field; delimiters are mostly escaped
  task automatic send_text(logic [7:0] b);
    if (b == BYTE_PIPE || b == BYTE_BSLASH || b == BYTE_NL) begin
      if ($urandom_range(15) != 0) send_item(MODE_DATA, BYTE_BSLASH);
    end else if ($urandom_range(40) == 0) begin
      send_item(MODE_DATA, BYTE_BSLASH);
    end
    send_item(MODE_DATA, b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [47:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLUMN_COUNT) cur_count = v[4:0];
    else cur_types = v;
  endtask

  task automatic send_field(logic [2:0] t);
    int n;
    for (int i = $urandom_range(2); i > 0; i--) send_text(" ");
    if (t == TYPE_CHAR) begin
      n = $urandom_range(3);
      for (int i = 0; i < n; i++)
        send_text(8'(($urandom_range(1) != 0) ? $urandom : "a" + i));
    end else if (t > TYPE_LONG) begin
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) send_text(8'($urandom));
    end else begin
      n = ($urandom_range(3) == 0) ? $urandom_range(15, 22) : $urandom_range(6);
      for (int i = 0; i < n; i++) send_text(8'("0" + $urandom_range(9)));
      if ($urandom_range(7) == 0) begin
        send_text("x");
        send_text(8'("0" + $urandom_range(9)));
      end
    end
  endtask

  task automatic send_row();
    int eff, nf;
    eff = (cur_count == 0) ? 1 : (cur_count > MAX_COLUMNS) ? MAX_COLUMNS : cur_count;
    nf = eff;
    if ($urandom_range(7) == 0) nf = $urandom_range(eff + 2);
    else if (eff > 4) nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      send_field((f < 16) ? cur_types[3*f +: 3] : TYPE_BINARY);
      if (f < nf - 1) send_item(MODE_DATA, BYTE_PIPE);
    end
    send_item(MODE_DATA, BYTE_NL);
  endtask

  task automatic run_phase(int target);
    int stop_at;
    stop_at = items_sent + target;
    send_item(MODE_START, 8'($urandom));
    while (items_sent < stop_at) begin
      case ($urandom_range(19))
        0: send_item(MODE_START, 8'($urandom));
        1: send_item(MODE_UNUSED, 8'($urandom));
        2: send_item(MODE_END, 8'($urandom));
        3: begin
          send_item(MODE_DATA, BYTE_BSLASH);
          send_item(MODE_END, 8'($urandom));
        end
        4: begin
          send_text(8'($urandom));
          send_item(MODE_END, 8'($urandom));
        end
        default: send_row();
      endcase
    end
    send_item(MODE_END, 8'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // four columns: char, short, long, long
    cfg_write(CFG_COLUMN_COUNT, 48'd4);
    cfg_write(CFG_COLUMN_TYPES, 48'h6C8);
    send_item(MODE_START, 8'h00);
    send_str(" q|99999|7\n");
    send_str("||||\n");
    send_item(MODE_UNUSED, 8'hFF);
    send_str("A|1");
    send_item(MODE_END, 8'hFF);
    send_item(MODE_DATA, BYTE_BSLASH);
    send_item(MODE_END, 8'h00);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 84; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 84; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      case (ph)
        0: begin
          cfg_write(CFG_COLUMN_COUNT, 48'd3);
          cfg_write(CFG_COLUMN_TYPES, 48'h0E3);
        end
        1: begin
          cfg_write(CFG_COLUMN_COUNT, 48'd0);
          cfg_write(CFG_COLUMN_TYPES, '1);
        end
        2: begin
          cfg_write(CFG_COLUMN_COUNT, 48'd16);
          cfg_write(CFG_COLUMN_TYPES, 48'({$urandom, $urandom}));
        end
        default: begin
          cfg_write(CFG_COLUMN_COUNT, 48'($urandom_range(17, 31)));
          cfg_write(CFG_COLUMN_TYPES, 48'({$urandom, $urandom}));
        end
      endcase
      if (ph == 0) hold_off = 400;
      run_phase(10);
      wait_drained();
    end

    cfg_write(CFG_COLUMN_COUNT, 48'd1);
    cfg_write(CFG_COLUMN_TYPES, 48'd0);
    run_phase(4);
    wait_drained();

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dtbc_pkg.sv
rtl/dtbc_ctrl.sv
rtl/dtbc_dp.sv
rtl/delimited_text_to_binary_copy_unit.sv
test/dtbc_checker.sv
test/tb.sv
